FILE: hdl/assert_macros.svh
// Assertion macros for the checker module of the framer.
// Depends on nothing; included by the files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is high
`define OWF_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("framer check failed");

// Concurrent check that also holds across reset
`define OWF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("framer reset check failed");

`endif

FILE: hdl/owf_pkg.sv
// Types and constants of the overlapping window framer.
// Used by the front, back, top level and checker.
package owf_pkg;

  localparam int ACTION_W   = 3;
  localparam int SAMPLE_W   = 16;
  localparam int WL_W       = 12;
  localparam int OL_W       = 11;
  localparam int LIMIT_W    = 15;
  localparam int COUNT_W    = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [WL_W-1:0]    WINDOW_RESET  = 12'd480;
  localparam logic [OL_W-1:0]    OVERLAP_RESET = 11'd160;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 15'd16384;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH   = 3'd0,
    ACT_FINISH = 3'd1,
    ACT_CANCEL = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_PULL   = 3'd4,
    ACT_QUERY  = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_REFUSED   = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_FINISHED  = 3'd3,
    ST_END       = 3'd4,
    ST_NOT_READY = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW  = 2'd0,
    CFG_OVERLAP = 2'd1,
    CFG_LIMIT   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [ACTION_W-1:0]        action;
    logic signed [SAMPLE_W-1:0] sample_in;
  } item_t;

  typedef struct packed {
    status_t                    status;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       window_first;
    logic                       window_last;
    logic                       ready_to_pull;
    logic                       is_finished;
    logic                       is_drained;
    logic                       is_cancelled;
    logic [COUNT_W-1:0]         pending_count;
  } result_t;

  typedef struct packed {
    action_t                    op;
    logic signed [SAMPLE_W-1:0] sample;
  } work_t;

endpackage

FILE: hdl/overlapping_window_framer_core.sv
// Stages: queue, execute stage, read stage register and output register.
// Throughput: one transaction per cycle when not stalled; the queue, execute
// stage and store read stage each take one, and the output register holds
// under back-pressure. Reset: synchronous, clears pointers, counters, flags and
// registers to their defaults; sample and overlap stores hold no reset value.
module overlapping_window_framer_core
  import owf_pkg::*;
#(
  parameter int BUFFER_DEPTH = 16384,
  parameter int MAX_WINDOW   = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic  work_valid;
  work_t work;
  logic  pop;

  owf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .pop        (pop),
    .work_valid (work_valid),
    .work       (work)
  );

  owf_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .MAX_WINDOW   (MAX_WINDOW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .work_valid   (work_valid),
    .work         (work),
    .pop          (pop),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

FILE: hdl/owf_front.sv
// Front of the framer: accepts transactions, classifies the action and
// queues the work for the back. Depends on owf_pkg.
module owf_front
  import owf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  input  logic  pop,
  output logic  work_valid,
  output work_t work
);

  localparam int QD  = 4;
  localparam int QAW = $clog2(QD);

  work_t          slots [QD];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   fill;
  logic [QAW:0]   fill_next;
  action_t        op_class;
  logic           push;

  // Map unknown codes to a status query
  always_comb begin
    case (item.action)
      ACT_PUSH, ACT_FINISH, ACT_CANCEL, ACT_CLEAR, ACT_PULL: begin
        op_class = action_t'(item.action);
      end
      default: begin
        op_class = ACT_QUERY;
      end
    endcase
  end

  assign item_ready = (fill != (QAW+1)'(QD));
  assign push       = item_valid && item_ready;
  assign work_valid = (fill != '0);
  assign work       = slots[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (push && !pop) begin
      fill_next = fill + 1'b1;
    end else if (pop && !push) begin
      fill_next = fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{op: op_class, sample: item.sample_in};
    end
  end

endmodule

FILE: hdl/owf_back.sv
// Back of the framer: configuration registers, sample and overlap stores,
// window sequencing, read stage and output register. Depends on owf_pkg.
module owf_back
  import owf_pkg::*;
#(
  parameter int BUFFER_DEPTH = 16384,
  parameter int MAX_WINDOW   = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  work_valid,
  input  work_t                 work,
  output logic                  pop,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result
);

  localparam int PEND_AW   = $clog2(BUFFER_DEPTH);
  localparam int CNT_W     = $clog2(BUFFER_DEPTH + 1);
  localparam int OVL_AW    = $clog2(MAX_WINDOW);
  localparam int WIN_CAP   = (MAX_WINDOW > 4095) ? 4095 : MAX_WINDOW;
  localparam int LCMP_W    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int RCMP_W    = (CNT_W > WL_W) ? CNT_W : WL_W;
  localparam logic [WL_W-1:0] WIN_CAP_V = WL_W'(WIN_CAP);

  typedef struct packed {
    status_t           status;
    logic              from_ovl;
    logic              from_pend;
    logic              wr_ovl;
    logic [OVL_AW-1:0] wa;
    logic              first;
    logic              last;
    logic              byp;
  } stage_t;

  // Configuration
  logic [WL_W-1:0]    window_length;
  logic [OL_W-1:0]    overlap_length;
  logic [LIMIT_W-1:0] buffer_limit;

  // Framing state
  logic [PEND_AW-1:0] head, head_next;
  logic [CNT_W-1:0]   fill, fill_next;
  logic [WL_W-1:0]    pos, pos_next;
  logic [WL_W-1:0]    take, take_next;
  logic               active, active_next;
  logic               started, started_next;
  logic               finished, finished_next;
  logic               cancelled, cancelled_next;
  logic [WL_W-1:0]    lat_window, lat_window_next;
  logic [WL_W-1:0]    lat_overlap, lat_overlap_next;
  logic [WL_W-1:0]    replay, replay_next;
  logic [WL_W-1:0]    ovl_valid, ovl_valid_next;
  logic [PEND_AW-1:0] base, base_next;

  // Stores
  logic signed [SAMPLE_W-1:0] pend_mem [BUFFER_DEPTH];
  logic signed [SAMPLE_W-1:0] ovl_mem [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] pend_q;
  logic signed [SAMPLE_W-1:0] ovl_q;

  // Derived configuration
  logic [WL_W-1:0]  eff_win, win_less1, eff_ovl, step, required;
  logic [LCMP_W-1:0] limit_cap;
  logic [CNT_W:0]   used;
  logic             fill_lt_req;
  logic [WL_W-1:0]  take_new;

  // Execute stage
  logic               adv;
  logic               do_exec;
  logic               start;
  logic [WL_W-1:0]    cw, co, rc, tk, wstep, off;
  logic [PEND_AW-1:0] bs;
  stage_t             s1;
  logic [OVL_AW-1:0]  ovl_ra;
  logic [PEND_AW-1:0] pend_ra;
  logic               pend_we;
  logic [PEND_AW-1:0] pend_wa;

  // Read stage
  logic                       s2_valid;
  stage_t                     s2;
  logic signed [SAMPLE_W-1:0] byp_data;
  logic signed [SAMPLE_W-1:0] v;
  logic                       ovl_we;

  function automatic logic [PEND_AW-1:0] wrap_add(input logic [PEND_AW:0] a,
                                                  input logic [PEND_AW:0] b);
    logic [PEND_AW:0] sum;
    sum = a + b;
    if (sum >= (PEND_AW+1)'(BUFFER_DEPTH)) begin
      sum = sum - (PEND_AW+1)'(BUFFER_DEPTH);
    end
    return sum[PEND_AW-1:0];
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= WINDOW_RESET;
      overlap_length <= OVERLAP_RESET;
      buffer_limit   <= LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WINDOW:  window_length  <= cfg_data[WL_W-1:0];
        CFG_OVERLAP: overlap_length <= cfg_data[OL_W-1:0];
        CFG_LIMIT:   buffer_limit   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (window_length == '0) begin
      eff_win = WL_W'(1);
    end else if (window_length > WIN_CAP_V) begin
      eff_win = WIN_CAP_V;
    end else begin
      eff_win = window_length;
    end
    win_less1 = eff_win - 1'b1;
    eff_ovl   = (WL_W'(overlap_length) > win_less1) ? win_less1 : WL_W'(overlap_length);
    step      = eff_win - eff_ovl;
    required  = started ? step : eff_win;
    limit_cap = (LCMP_W'(buffer_limit) > LCMP_W'(BUFFER_DEPTH)) ?
                LCMP_W'(BUFFER_DEPTH) : LCMP_W'(buffer_limit);
    used      = (CNT_W+1)'(fill) + (active ? (CNT_W+1)'(take) : '0);
    fill_lt_req = RCMP_W'(fill) < RCMP_W'(required);
    take_new  = fill_lt_req ? WL_W'(fill) : required;
  end

  assign adv     = !result_valid || result_ready;
  assign do_exec = work_valid && adv;
  assign pop     = do_exec;

  always_comb begin
    head_next        = head;
    fill_next        = fill;
    pos_next         = pos;
    take_next        = take;
    active_next      = active;
    started_next     = started;
    finished_next    = finished;
    cancelled_next   = cancelled;
    lat_window_next  = lat_window;
    lat_overlap_next = lat_overlap;
    replay_next      = replay;
    ovl_valid_next   = ovl_valid;
    base_next        = base;
    start            = 1'b0;
    s1               = '{status: ST_OK, default: '0};
    pend_we          = 1'b0;
    pend_wa          = wrap_add((PEND_AW+1)'(head), (PEND_AW+1)'(fill));
    cw               = start ? eff_win : lat_window;
    co               = lat_overlap;
    rc               = replay;
    tk               = take;
    bs               = base;
    wstep            = '0;
    off              = '0;
    pend_ra          = '0;
    ovl_ra           = OVL_AW'(pos);

    case (work.op)
      ACT_PUSH: begin
        if (finished || cancelled || (LCMP_W'(fill) >= limit_cap) ||
            (used >= (CNT_W+1)'(BUFFER_DEPTH))) begin
          s1.status = ST_REFUSED;
        end else begin
          pend_we   = do_exec;
          fill_next = fill + 1'b1;
        end
      end
      ACT_FINISH: begin
        if (cancelled) begin
          s1.status = ST_CANCELLED;
        end else if (finished) begin
          s1.status = ST_FINISHED;
        end else begin
          finished_next = 1'b1;
        end
      end
      ACT_CANCEL: begin
        cancelled_next = 1'b1;
      end
      ACT_CLEAR: begin
        head_next        = '0;
        fill_next        = '0;
        pos_next         = '0;
        take_next        = '0;
        active_next      = 1'b0;
        started_next     = 1'b0;
        finished_next    = 1'b0;
        cancelled_next   = 1'b0;
        lat_window_next  = '0;
        lat_overlap_next = '0;
        replay_next      = '0;
        ovl_valid_next   = '0;
        base_next        = '0;
      end
      ACT_PULL: begin
        if (!active) begin
          if (cancelled) begin
            s1.status = ST_CANCELLED;
          end else if (finished && (fill == '0)) begin
            s1.status = ST_END;
          end else if (fill_lt_req && !finished) begin
            s1.status = ST_NOT_READY;
          end else begin
            start = 1'b1;
          end
        end
        if (s1.status == ST_OK) begin
          cw = start ? eff_win : lat_window;
          co = start ? eff_ovl : lat_overlap;
          rc = start ? (started ? ovl_valid : '0) : replay;
          tk = start ? take_new : take;
          bs = start ? head : base;
          if (start) begin
            lat_window_next  = cw;
            lat_overlap_next = co;
            replay_next      = rc;
            ovl_valid_next   = eff_ovl;
            take_next        = tk;
            base_next        = bs;
            head_next        = wrap_add((PEND_AW+1)'(head), (PEND_AW+1)'(take_new));
            fill_next        = fill - CNT_W'(take_new);
            active_next      = 1'b1;
            started_next     = 1'b1;
          end
          wstep        = cw - co;
          off          = pos - rc;
          s1.from_ovl  = pos < rc;
          s1.from_pend = !s1.from_ovl && (off < tk);
          pend_ra      = wrap_add((PEND_AW+1)'(bs), (PEND_AW+1)'(off));
          s1.wr_ovl    = pos >= wstep;
          s1.wa        = OVL_AW'(pos - wstep);
          s1.first     = (pos == '0);
          if (({1'b0, pos} + 1'b1) >= {1'b0, cw}) begin
            s1.last     = 1'b1;
            active_next = 1'b0;
            pos_next    = '0;
            take_next   = '0;
          end else begin
            pos_next = pos + 1'b1;
          end
        end
      end
      default: ;
    endcase

    s1.byp = ovl_we && (s2.wa == ovl_ra);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      fill        <= '0;
      pos         <= '0;
      take        <= '0;
      active      <= 1'b0;
      started     <= 1'b0;
      finished    <= 1'b0;
      cancelled   <= 1'b0;
      lat_window  <= '0;
      lat_overlap <= '0;
      replay      <= '0;
      ovl_valid   <= '0;
      base        <= '0;
    end else if (do_exec) begin
      head        <= head_next;
      fill        <= fill_next;
      pos         <= pos_next;
      take        <= take_next;
      active      <= active_next;
      started     <= started_next;
      finished    <= finished_next;
      cancelled   <= cancelled_next;
      lat_window  <= lat_window_next;
      lat_overlap <= lat_overlap_next;
      replay      <= replay_next;
      ovl_valid   <= ovl_valid_next;
      base        <= base_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pend_wa] <= work.sample;
    end
    if (adv) begin
      pend_q <= pend_mem[pend_ra];
    end
  end

  // Overlap tail: written from the read stage, bypass a same-cycle read
  assign ovl_we = adv && s2_valid && s2.wr_ovl;

  always_ff @(posedge clk) begin
    if (ovl_we) begin
      ovl_mem[s2.wa] <= v;
    end
    if (adv) begin
      ovl_q <= ovl_mem[ovl_ra];
    end
  end

  always_comb begin
    if (s2.from_ovl) begin
      v = s2.byp ? byp_data : ovl_q;
    end else if (s2.from_pend) begin
      v = pend_q;
    end else begin
      v = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      s2_valid     <= do_exec;
      result_valid <= s2_valid;
    end
  end

  // Flags come from the state as left by the item in the read stage
  always_ff @(posedge clk) begin
    if (adv) begin
      s2       <= s1;
      byp_data <= v;
      result.status        <= s2.status;
      result.sample_out    <= v;
      result.window_first  <= s2.first;
      result.window_last   <= s2.last;
      result.ready_to_pull <= cancelled || !fill_lt_req || (finished && (fill != '0));
      result.is_finished   <= finished;
      result.is_drained    <= finished && (fill == '0);
      result.is_cancelled  <= cancelled;
      result.pending_count <= COUNT_W'(fill);
    end
  end

endmodule

FILE: hdl/owf_checker.sv
// Port-level checks of the framer, bound to the top level.
// Depends on owf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module owf_checker
  import owf_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  `OWF_ASSERT(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(result))
  `OWF_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid)
  `OWF_ASSERT_ALWAYS(a_reset_ready, clk, rst |=> item_ready)
  `OWF_ASSERT(a_drained, clk, rst, result_valid && result.is_drained |-> result.is_finished && (result.pending_count == '0))

endmodule

bind overlapping_window_framer_core owf_checker u_owf_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
